// ----- src/ccp_pkg.sv -----
`timescale 1ns / 1ps

package ccp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_CHUNK  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
  localparam logic [2:0] ST_BAD_VER    = 3'd2;
  localparam logic [2:0] ST_COMPRESSED = 3'd3;
  localparam logic [2:0] ST_ILLEGAL    = 3'd4;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd5;
  localparam logic [2:0] ST_BAD_HSIZE  = 3'd6;

  // Stop reasons
  localparam logic [1:0] STOP_END_DATA = 2'd0;
  localparam logic [1:0] STOP_MARKER   = 2'd1;
  localparam logic [1:0] STOP_ZERO     = 2'd2;
  localparam logic [1:0] STOP_OVERRUN  = 2'd3;

  localparam logic [63:0] FILE_MAGIC   = 64'h5046_502D_4669_6C65;
  localparam logic [7:0]  FMT_VERSION  = 8'd3;
  localparam logic [31:0] NAME_END     = 32'h454E_4446;
  localparam logic [31:0] NAME_UNKNOWN = 32'h554E_4B4E;
  localparam int          HDR_BYTES    = 24;
  localparam int          HDR_SIZE_MIN = 17;
  localparam int          CHUNK_HDR    = 8;

  // Result queue geometry
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  status;
    logic [1:0]  stop_reason;
    logic [31:0] tag;
    logic [7:0]  main_version;
    logic [7:0]  sub_version;
    logic [7:0]  compression;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic        last;
  } res_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [5:0] sh;
    sh = 6'(3'd7 - idx) << 3;
    return 8'(FILE_MAGIC >> sh);
  endfunction

  function automatic res_t mk_finish(input logic [2:0] st, input logic [1:0] stop);
    res_t r;
    r = '0;
    r.result_kind = KIND_FINISH;
    r.status      = st;
    r.stop_reason = stop;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

// ----- src/ccp_result_fifo.sv -----
`timescale 1ns / 1ps

module ccp_result_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  ccp_pkg::res_t push0,
  input  ccp_pkg::res_t push1,
  output logic          room2,
  output logic          out_valid,
  input  logic          out_ready,
  output ccp_pkg::res_t out_data
);
  import ccp_pkg::*;

  res_t                mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wptr_r, rptr_r;
  logic [RQ_CNT_W-1:0] cnt_r;
  logic                pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rptr_r];
  assign room2     = (cnt_r <= RQ_CNT_W'(RQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wptr_r + RQ_PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + RQ_PTR_W'(push_n);
      if (pop) begin
        rptr_r <= rptr_r + RQ_PTR_W'(1);
      end
      cnt_r <= cnt_r + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
    end
  end

endmodule

// ----- src/chunked_container_parser.sv -----
`timescale 1ns / 1ps
// Flow: a word accepted into the input stage register is parsed once the
// result queue has room for two results, which are written into that queue.
// Throughput: one input word per cycle while the queue has room for two
// results; words that yield two results are absorbed by a four-entry queue.
// Reset: synchronous, active low; the parser waits for a first-byte word.
module chunked_container_parser #(
  parameter int OFFSET_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,  // data_byte[7:0], total_length[39:8]
  input  logic         in_tuser,  // first_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], stop_reason[4:3], tag[36:5], main_version[44:37],
  // sub_version[52:45], compression[60:53], data_offset[92:61],
  // data_size[124:93], zero fill[127:125]
  output logic [127:0] out_tdata,
  output logic [1:0]   out_tuser, // result_kind
  output logic         out_tlast  // last
);
  import ccp_pkg::*;

  localparam int OB = OFFSET_BITS;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_CHUNK, PH_DONE} phase_t;

  // Input stage: hold one word until the queue has room for its results
  logic         stg_v_r;
  logic [7:0]   stg_byte_r;
  logic         stg_first_r;
  logic [31:0]  stg_total_r;

  // Parser state
  phase_t       phase_r, phase_nxt;
  logic [OB-1:0] pos_r, pos_nxt;
  logic [7:0]   hsize_r, hsize_nxt;
  logic [31:0]  file_id_r, file_id_nxt;
  logic [7:0]   main_r, main_nxt, sub_r, sub_nxt, comp_r, comp_nxt;
  logic [63:0]  shift_r, shift_nxt;
  logic [OB-1:0] start_r, start_nxt;
  logic         magic_r, magic_nxt;

  logic         room2, fire;
  logic [1:0]   push_n;
  res_t         r0, r1, q;

  // Working values
  logic [63:0]   total_ext;
  logic [OB-1:0] total_c, pos_e, next_s;
  logic          magic_e, do_next;
  phase_t        phase_e;
  logic [31:0]   name, size;
  logic [32:0]   end_sum;
  logic [OB:0]   off_sum;

  assign fire      = stg_v_r && room2;
  assign in_tready = !stg_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_tready) begin
      stg_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_byte_r  <= in_tdata[7:0];
      stg_total_r <= in_tdata[39:8];
      stg_first_r <= in_tuser;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    hsize_nxt   = hsize_r;
    file_id_nxt = file_id_r;
    main_nxt    = main_r;
    sub_nxt     = sub_r;
    comp_nxt    = comp_r;
    shift_nxt   = shift_r;
    start_nxt   = start_r;
    magic_nxt   = magic_r;
    r0          = '0;
    r1          = '0;
    push_n      = 2'd0;
    do_next     = 1'b0;
    next_s      = '0;

    // Clamp the file length to the offset range
    total_ext = {32'd0, stg_total_r};
    total_c   = ((total_ext >> OB) != 64'd0) ? {OB{1'b1}} : stg_total_r[OB-1:0];

    // A first-byte word restarts the parser with this very byte
    pos_e   = stg_first_r ? '0 : pos_r;
    magic_e = stg_first_r ? 1'b1 : magic_r;
    phase_e = stg_first_r ? PH_HEADER : phase_r;

    name    = shift_nxt[63:32];
    size    = '0;
    end_sum = '0;
    off_sum = '0;

    if (fire) begin
      if (stg_first_r) begin
        phase_nxt   = PH_HEADER;
        pos_nxt     = '0;
        hsize_nxt   = '0;
        file_id_nxt = '0;
        main_nxt    = '0;
        sub_nxt     = '0;
        comp_nxt    = '0;
        shift_nxt   = '0;
        start_nxt   = '0;
        magic_nxt   = 1'b1;
      end

      if (phase_e == PH_HEADER || phase_e == PH_CHUNK) begin
        shift_nxt = {(stg_first_r ? 56'd0 : shift_r[55:0]), stg_byte_r};
        name      = shift_nxt[63:32];
        size      = {shift_nxt[7:0], shift_nxt[15:8], shift_nxt[23:16], shift_nxt[31:24]};
        end_sum   = {{(33-OB){1'b0}}, start_r} + {1'b0, size};
        off_sum   = {1'b0, start_r} + (OB+1)'(CHUNK_HDR);
        pos_nxt   = (pos_e != {OB{1'b1}}) ? pos_e + OB'(1) : pos_e;

        if (phase_e == PH_HEADER) begin
          if (pos_e == '0 && total_c < OB'(HDR_BYTES)) begin
            r0 = mk_finish(ST_TOO_SHORT, STOP_END_DATA);
            push_n = 2'd1;
            phase_nxt = PH_DONE;
          end else if (pos_e < OB'(8)) begin
            if (stg_byte_r != magic_byte(pos_e[2:0])) begin
              magic_nxt = 1'b0;
            end else begin
              magic_nxt = magic_e;
            end
            if (pos_e == OB'(7) && !magic_nxt) begin
              r0 = mk_finish(ST_BAD_MAGIC, STOP_END_DATA);
              push_n = 2'd1;
              phase_nxt = PH_DONE;
            end
          end else if (pos_e == OB'(8)) begin
            if (stg_byte_r != FMT_VERSION) begin
              r0 = mk_finish(ST_BAD_VER, STOP_END_DATA);
              push_n = 2'd1;
              phase_nxt = PH_DONE;
            end
          end else if (pos_e == OB'(9)) begin
            hsize_nxt = stg_byte_r;
          end else if (pos_e <= OB'(13)) begin
            file_id_nxt = {file_id_r[23:0], stg_byte_r};
          end else if (pos_e == OB'(14)) begin
            sub_nxt = stg_byte_r;
          end else if (pos_e == OB'(15)) begin
            main_nxt = stg_byte_r;
          end else if (pos_e == OB'(16)) begin
            comp_nxt = stg_byte_r;
          end else if (pos_e == OB'(HDR_BYTES - 1)) begin
            r0.result_kind  = KIND_HEADER;
            r0.tag          = file_id_r;
            r0.main_version = main_r;
            r0.sub_version  = sub_r;
            r0.compression  = comp_r;
            push_n = 2'd1;
            if (comp_r != 8'd0) begin
              r1 = mk_finish(ST_COMPRESSED, STOP_END_DATA);
              push_n = 2'd2;
              phase_nxt = PH_DONE;
            end else if (hsize_r < 8'(HDR_SIZE_MIN)) begin
              r1 = mk_finish(ST_BAD_HSIZE, STOP_END_DATA);
              push_n = 2'd2;
              phase_nxt = PH_DONE;
            end else if ({{(OB-8){1'b0}}, hsize_r} > total_c) begin
              r1 = mk_finish(ST_TOO_SHORT, STOP_END_DATA);
              push_n = 2'd2;
              phase_nxt = PH_DONE;
            end else begin
              do_next = 1'b1;
              next_s  = {{(OB-8){1'b0}}, hsize_r};
            end
          end
        end else if ({1'b0, pos_e} == {1'b0, start_r} + (OB+1)'(CHUNK_HDR - 1)) begin
          // Last byte of a chunk header: checks in priority order
          push_n = 2'd1;
          if (name == NAME_END) begin
            r0 = mk_finish(ST_OK, STOP_MARKER);
            phase_nxt = PH_DONE;
          end else if (size == 32'd0) begin
            r0 = mk_finish(ST_OK, STOP_ZERO);
            phase_nxt = PH_DONE;
          end else if (size < 32'(CHUNK_HDR)) begin
            r0 = mk_finish(ST_BAD_HSIZE, STOP_END_DATA);
            phase_nxt = PH_DONE;
          end else if (end_sum > {{(33-OB){1'b0}}, total_c}) begin
            r0 = mk_finish(ST_OK, STOP_OVERRUN);
            phase_nxt = PH_DONE;
          end else if (name == NAME_UNKNOWN) begin
            r0 = mk_finish(ST_ILLEGAL, STOP_END_DATA);
            phase_nxt = PH_DONE;
          end else begin
            r0.result_kind = KIND_CHUNK;
            r0.tag         = name;
            r0.data_offset = 32'(off_sum);
            r0.data_size   = size - 32'(CHUNK_HDR);
            do_next = 1'b1;
            next_s  = end_sum[OB-1:0];
          end
        end

        // Next chunk start: end of data, or too few bytes left for a header
        if (do_next) begin
          if (next_s == total_c) begin
            r1 = mk_finish(ST_OK, STOP_END_DATA);
            push_n = 2'd2;
            phase_nxt = PH_DONE;
          end else if ({1'b0, next_s} + (OB+1)'(CHUNK_HDR) > {1'b0, total_c}) begin
            r1 = mk_finish(ST_OK, STOP_OVERRUN);
            push_n = 2'd2;
            phase_nxt = PH_DONE;
          end else begin
            start_nxt = next_s;
            phase_nxt = PH_CHUNK;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pos_r     <= '0;
      hsize_r   <= '0;
      file_id_r <= '0;
      main_r    <= '0;
      sub_r     <= '0;
      comp_r    <= '0;
      shift_r   <= '0;
      start_r   <= '0;
      magic_r   <= 1'b1;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      hsize_r   <= hsize_nxt;
      file_id_r <= file_id_nxt;
      main_r    <= main_nxt;
      sub_r     <= sub_nxt;
      comp_r    <= comp_nxt;
      shift_r   <= shift_nxt;
      start_r   <= start_nxt;
      magic_r   <= magic_nxt;
    end
  end

  // Results wait here; the input side stalls only when two slots are not free
  ccp_result_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (r0),
    .push1     (r1),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q)
  );

  assign out_tdata = {3'b000, q.data_size, q.data_offset, q.compression, q.sub_version,
                      q.main_version, q.tag, q.stop_reason, q.status};
  assign out_tuser = q.result_kind;
  assign out_tlast = q.last;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  // Block-level test of chunked_container_parser.
  // Files are built byte by byte in a queue and streamed into the parser one
  // word per byte. An own tracker of the parse state works out the header,
  // chunk and finish results that each accepted word should cause, and a
  // checker compares every result word with the oldest one still due.
  // Directed files cover the header faults and every way a chunk walk can
  // stop. Then an output hold-off fills the result queue. Random files finish
  // the run, most of them well formed and the rest damaged or noise.
  import ccp_pkg::*;

  localparam int CYCLE_LIMIT  = 300_000;
  localparam int RANDOM_WORDS = 120;
  localparam int SHOWN_ERRORS = 10;
  localparam logic [1:0] STOP_NONE = '0;  // stop field on error finishes

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_CHUNK, PH_DONE} phase_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  always #4 clk = ~clk;

  chunked_container_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Parse state as the block should hold it
  phase_t      p_phase = PH_IDLE;
  logic [31:0] p_pos = '0;
  logic [7:0]  p_hsize = '0;
  logic [31:0] p_id = '0;
  logic [7:0]  p_main = '0;
  logic [7:0]  p_sub = '0;
  logic [7:0]  p_comp = '0;
  logic [63:0] p_window = '0;  // last eight bytes, newest lowest
  logic [31:0] p_next = '0;
  bit          p_magic_ok = 1'b1;

  res_t        due_results[$];
  logic [7:0]  file_bytes[$];

  int  words_sent = 0;
  int  files_sent = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  input_stalls = 0;
  int  cycles = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  int  hold_requests = 0;
  int  hold_len = 0;

  // ---------------------------------------------------------------------
  // Expected-result tracking
  // ---------------------------------------------------------------------
  task automatic queue_result(input res_t r);
    due_results = {due_results, r};
  endtask

  task automatic close_file(input logic [2:0] st, input logic [1:0] stop);
    res_t r;
    r = '0;
    r.result_kind = KIND_FINISH;
    r.status      = st;
    r.stop_reason = stop;
    r.last        = 1'b1;
    queue_result(r);
    p_phase = PH_DONE;
  endtask

  // Arm the next chunk, or end the file when no whole chunk header fits
  task automatic arm_chunk(input logic [63:0] start, input logic [63:0] tot);
    if (start == tot) begin
      close_file(ST_OK, STOP_END_DATA);
    end else if (start + 64'd8 > tot) begin
      close_file(ST_OK, STOP_OVERRUN);
    end else begin
      p_next  = start[31:0];
      p_phase = PH_CHUNK;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input bit first, input logic [31:0] total);
    logic [63:0] tot;
    logic [63:0] start;
    logic [63:0] csize;
    logic [31:0] name;
    logic [31:0] raw;
    res_t        r;
    if (first) begin
      p_phase    = PH_HEADER;
      p_pos      = '0;
      p_hsize    = '0;
      p_id       = '0;
      p_main     = '0;
      p_sub      = '0;
      p_comp     = '0;
      p_window   = '0;
      p_next     = '0;
      p_magic_ok = 1'b1;
    end
    if (p_phase != PH_HEADER && p_phase != PH_CHUNK) return;
    tot      = {32'd0, total};
    p_window = {p_window[55:0], b};
    if (p_phase == PH_HEADER) begin
      if (p_pos == 32'd0 && total < HDR_BYTES) begin
        close_file(ST_TOO_SHORT, STOP_NONE);
      end else if (p_pos < 32'd8) begin
        if (b != FILE_MAGIC[8 * (7 - p_pos[2:0]) +: 8]) p_magic_ok = 1'b0;
        if (p_pos == 32'd7 && !p_magic_ok) close_file(ST_BAD_MAGIC, STOP_NONE);
      end else if (p_pos == 32'd8) begin
        if (b != FMT_VERSION) close_file(ST_BAD_VER, STOP_NONE);
      end else if (p_pos == 32'd9) begin
        p_hsize = b;
      end else if (p_pos <= 32'd13) begin
        p_id = {p_id[23:0], b};
      end else if (p_pos == 32'd14) begin
        p_sub = b;
      end else if (p_pos == 32'd15) begin
        p_main = b;
      end else if (p_pos == 32'd16) begin
        p_comp = b;
      end else if (p_pos == 32'd23) begin
        r = '0;
        r.result_kind  = KIND_HEADER;
        r.status       = ST_OK;
        r.tag          = p_id;
        r.main_version = p_main;
        r.sub_version  = p_sub;
        r.compression  = p_comp;
        queue_result(r);
        if (p_comp != 8'd0) close_file(ST_COMPRESSED, STOP_NONE);
        else if (p_hsize < HDR_SIZE_MIN) close_file(ST_BAD_HSIZE, STOP_NONE);
        else if ({24'd0, p_hsize} > total) close_file(ST_TOO_SHORT, STOP_NONE);
        else arm_chunk({56'd0, p_hsize}, tot);
      end
    end else if ({32'd0, p_pos} == {32'd0, p_next} + 64'd7) begin
      start = {32'd0, p_next};
      name  = p_window[63:32];
      raw   = p_window[31:0];
      // the size arrives least significant byte first
      csize = {32'd0, raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
      if (name == NAME_END) begin
        close_file(ST_OK, STOP_MARKER);
      end else if (csize == 64'd0) begin
        close_file(ST_OK, STOP_ZERO);
      end else if (csize < CHUNK_HDR) begin
        close_file(ST_BAD_HSIZE, STOP_NONE);
      end else if (start + csize > tot) begin
        close_file(ST_OK, STOP_OVERRUN);
      end else if (name == NAME_UNKNOWN) begin
        close_file(ST_ILLEGAL, STOP_NONE);
      end else begin
        r = '0;
        r.result_kind = KIND_CHUNK;
        r.status      = ST_OK;
        r.tag         = name;
        r.data_offset = 32'(start + 64'd8);
        r.data_size   = 32'(csize - 64'd8);
        queue_result(r);
        arm_chunk(start + csize, tot);
      end
    end
    if (p_pos != 32'hFFFF_FFFF) p_pos++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] random_name();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return NAME_END;
    if (r == 1) return NAME_UNKNOWN;
    return $urandom;
  endfunction

  task automatic append_byte(input logic [7:0] b);
    file_bytes = {file_bytes, b};
  endtask

  task automatic send_word(input logic [7:0] b, input bit first, input logic [31:0] total);
    int gap;
    in_tdata  <= {total, b};
    in_tuser  <= first;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    parse_byte(b, first, total);
    words_sent++;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stream the first count bytes of the file under construction
  task automatic send_file(input logic [31:0] total, input int count);
    int i;
    for (i = 0; i < count; i++) send_word(file_bytes[i], i == 0, total);
    files_sent++;
  endtask

  task automatic send_whole_file();
    send_file(32'(file_bytes.size()), file_bytes.size());
  endtask

  // Start a new file: magic, version, header size, id, versions, compression,
  // then filler up to where the first chunk begins
  task automatic add_header(input logic [7:0] ver, input logic [7:0] hs,
                            input logic [31:0] id, input logic [7:0] sub,
                            input logic [7:0] mainv, input logic [7:0] comp);
    int i;
    int pad_to;
    file_bytes.delete();
    for (i = 0; i < 8; i++) append_byte(FILE_MAGIC[8 * (7 - i) +: 8]);
    append_byte(ver);
    append_byte(hs);
    for (i = 3; i >= 0; i--) append_byte(id[8 * i +: 8]);
    append_byte(sub);
    append_byte(mainv);
    append_byte(comp);
    pad_to = (hs >= HDR_SIZE_MIN) ? int'(hs) : HDR_BYTES;
    while (file_bytes.size() < pad_to) append_byte(8'($urandom));
  endtask

  task automatic add_chunk(input logic [31:0] name, input logic [31:0] csize, input int plen);
    int i;
    for (i = 3; i >= 0; i--) append_byte(name[8 * i +: 8]);
    for (i = 0; i < 4; i++) append_byte(csize[8 * i +: 8]);
    for (i = 0; i < plen; i++) append_byte(8'($urandom));
  endtask

  // Drop valid and hold until every due result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_ignored_before_start();
    send_word(8'h00, 1'b0, 32'h0000_0000);
    send_word(8'hFF, 1'b0, 32'hFFFF_FFFF);
    send_word(8'h50, 1'b0, 32'd100);
    wait_drained();
  endtask

  task automatic test_short_files();
    int i;
    // empty length: finish on the very first byte
    file_bytes.delete();
    append_byte(8'hFF);
    send_whole_file();
    // one byte short of a header, with the rest of it ignored after the finish
    add_header(FMT_VERSION, 8'd24, 32'h1234_5678, 8'd1, 8'd2, 8'd0);
    send_file(32'd23, 24);
    for (i = 0; i < 3; i++) send_word(8'($urandom), 1'b0, 32'd23);
    // header fills the file exactly: first chunk start equals the length
    add_header(FMT_VERSION, 8'd24, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'd0);
    send_whole_file();
    wait_drained();
  endtask

  task automatic test_header_faults();
    // magic and version faults end the file early, so stop sending there
    add_header(FMT_VERSION, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    file_bytes[3] = file_bytes[3] ^ 8'h01;
    send_file(32'(HDR_BYTES), 8);
    add_header(FMT_VERSION, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    file_bytes[0] = 8'h00;
    file_bytes[7] = 8'hFF;
    send_file(32'(HDR_BYTES), 8);
    add_header(8'd2, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    send_file(32'(HDR_BYTES), 9);
    add_header(8'hFF, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    send_file(32'(HDR_BYTES), 9);
    // compressed, then the header size faults
    add_header(FMT_VERSION, 8'd24, 32'hA5A5_5A5A, 8'h00, 8'hFF, 8'hFF);
    send_whole_file();
    add_header(FMT_VERSION, 8'd16, 32'h0102_0304, 8'd1, 8'd1, 8'd0);
    send_whole_file();
    add_header(FMT_VERSION, 8'd0, 32'h0102_0304, 8'd1, 8'd1, 8'd0);
    send_whole_file();
    add_header(FMT_VERSION, 8'd255, 32'h0, 8'd0, 8'd0, 8'd0);
    send_file(32'd30, 30);
    // fewer than eight bytes left for the first chunk header
    add_header(FMT_VERSION, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    add_chunk(32'h4441_5441, 32'd8, 0);
    send_file(32'd28, 28);
    wait_drained();
  endtask

  task automatic test_chunk_stops();
    // ordinary chunks, then the end marker
    add_header(FMT_VERSION, 8'd24, 32'h0, 8'd3, 8'd4, 8'd0);
    add_chunk(32'h0000_0000, 32'd8, 0);
    add_chunk(32'hFFFF_FFFF, 32'd12, 4);
    add_chunk(NAME_END, 32'd0, 0);
    send_whole_file();
    add_header(FMT_VERSION, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    add_chunk(32'h4142_4344, 32'd0, 0);
    send_whole_file();
    add_header(FMT_VERSION, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    add_chunk(32'h4142_4344, 32'd1, 0);
    send_whole_file();
    add_header(FMT_VERSION, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    add_chunk(32'h4142_4344, 32'd7, 0);
    send_whole_file();
    add_header(FMT_VERSION, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    add_chunk(32'h4142_4344, 32'd40, 4);
    send_whole_file();
    add_header(FMT_VERSION, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    add_chunk(NAME_UNKNOWN, 32'd10, 2);
    send_whole_file();
    // last chunk ends exactly at the file end; header size below the header
    add_header(FMT_VERSION, 8'd17, 32'h0, 8'd0, 8'd0, 8'd0);
    add_chunk(32'h5859_5A5A, 32'd16, 8);
    send_whole_file();
    wait_drained();
  endtask

  task automatic test_wide_lengths();
    // chunk reaching the top of the offset range, then one that overruns it
    add_header(FMT_VERSION, 8'd24, 32'h8000_0001, 8'd0, 8'd0, 8'd0);
    add_chunk(32'h4249_4743, 32'hFFFF_FFE7, 0);
    send_file(32'hFFFF_FFFF, file_bytes.size());
    add_header(FMT_VERSION, 8'd24, 32'h7FFF_FFFE, 8'd0, 8'd0, 8'd0);
    add_chunk(32'h4249_4743, 32'hFFFF_FFFF, 0);
    send_file(32'hFFFF_FFFF, file_bytes.size());
    wait_drained();
  endtask

  task automatic test_restart_mid_file();
    add_header(FMT_VERSION, 8'd24, 32'hDEAD_BEEF, 8'd0, 8'd0, 8'd0);
    send_file(32'd48, 12);
    add_header(FMT_VERSION, 8'd24, 32'hCAFE_F00D, 8'd9, 8'd8, 8'd0);
    add_chunk(32'h4D49_4444, 32'd8, 0);
    send_whole_file();
    wait_drained();
  endtask

  // Hold the output off while a run of tiny chunks streams in, so the
  // result queue fills and the parser has to stall its input
  task automatic test_backpressure();
    int i;
    add_header(FMT_VERSION, 8'd24, 32'h0, 8'd0, 8'd0, 8'd0);
    for (i = 0; i < 6; i++) add_chunk($urandom, 32'd8, 0);
    tx_steady = 1'b1;
    hold_len  = 400;
    hold_requests++;
    send_whole_file();
    tx_steady = 1'b0;
    wait_drained();
  endtask

  task automatic send_random_file();
    int          i;
    int          n;
    int          plen;
    logic [7:0]  hs;
    logic [31:0] total;
    if ($urandom_range(0, 99) < 8) begin
      // noise: random bytes under a random length
      file_bytes.delete();
      n = $urandom_range(1, 40);
      for (i = 0; i < n; i++) append_byte(8'($urandom));
      send_file($urandom, n);
      return;
    end
    hs = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(17, 40)) : 8'(HDR_BYTES);
    add_header(FMT_VERSION, hs, $urandom, 8'($urandom), 8'($urandom),
               ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
    n = $urandom_range(0, 5);
    for (i = 0; i < n; i++) begin
      plen = $urandom_range(0, 12);
      add_chunk(random_name(), 32'(plen + 8), plen);
    end
    plen = $urandom_range(0, 6);
    case ($urandom_range(0, 5))
      0: ;  // run into the end of data
      1: add_chunk(NAME_END, $urandom, 0);
      2: add_chunk(random_name(), 32'd0, 0);
      3: for (i = 0; i < plen + 1; i++) append_byte(8'($urandom));
      4: add_chunk(random_name(), 32'(plen + 8 + $urandom_range(1, 200)), plen);
      default: begin
        if ($urandom_range(0, 1) == 1) add_chunk(NAME_UNKNOWN, 32'(plen + 8), plen);
        else add_chunk(random_name(), 32'($urandom_range(1, 7)), 0);
      end
    endcase
    total = 32'(file_bytes.size());
    n     = file_bytes.size();
    // damage a minority: flip a byte, claim a longer file, or cut it short
    if ($urandom_range(0, 9) == 0) begin
      i = $urandom_range(0, n - 1);
      file_bytes[i] = file_bytes[i] ^ 8'(1 << $urandom_range(0, 7));
    end
    if ($urandom_range(0, 9) == 0) total = total + 32'($urandom_range(1, 50));
    if ($urandom_range(0, 14) == 0) n = $urandom_range(1, n);
    send_file(total, n);
  endtask

  task automatic test_random_files();
    int base;
    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      // every so often a stretch with no idling on either side
      tx_steady = (files_sent % 10 == 0);
      rx_steady = tx_steady;
      send_random_file();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Output ready: random gaps, plus long holds on request
  // ---------------------------------------------------------------------
  initial begin : ready_gen
    int hold_left;
    int seen;
    int gap_left;
    hold_left = 0;
    seen      = 0;
    gap_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen) begin
        seen      = hold_requests;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else begin
        out_tready <= 1'b1;
        gap_left = rx_steady ? 0 : pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  task automatic report_result(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) begin
      $display("%s at cycle %0d", what, cycles);
      $display("  want kind=%0d st=%0d stop=%0d tag=%h ver=%h.%h comp=%h off=%h size=%h last=%0b",
               want.result_kind, want.status, want.stop_reason, want.tag, want.main_version,
               want.sub_version, want.compression, want.data_offset, want.data_size, want.last);
      $display("  got  kind=%0d st=%0d stop=%0d tag=%h ver=%h.%h comp=%h off=%h size=%h last=%0b",
               got.result_kind, got.status, got.stop_reason, got.tag, got.main_version,
               got.sub_version, got.compression, got.data_offset, got.data_size, got.last);
    end
  endtask

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d results still due", due_results.size());
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && in_tvalid && !in_tready) input_stalls++;
    if (rst_n && out_tvalid && out_tready) begin
      got.result_kind  = out_tuser;
      got.status       = out_tdata[2:0];
      got.stop_reason  = out_tdata[4:3];
      got.tag          = out_tdata[36:5];
      got.main_version = out_tdata[44:37];
      got.sub_version  = out_tdata[52:45];
      got.compression  = out_tdata[60:53];
      got.data_offset  = out_tdata[92:61];
      got.data_size    = out_tdata[124:93];
      got.last         = out_tlast;
      results_seen++;
      if (due_results.size() == 0) begin
        report_result("Result word with none due", '0, got);
      end else begin
        want = due_results.pop_front();
        if (got !== want) report_result("Result word mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ignored_before_start();
    test_short_files();
    test_header_faults();
    test_chunk_stops();
    test_wide_lengths();
    test_restart_mid_file();
    test_backpressure();
    test_random_files();

    wait_drained();
    repeat (20) @(posedge clk);
    mismatches += due_results.size();

    $display("Parsed %0d files in %0d words; %0d result words checked, input stalled %0d cycles",
             files_sent, words_sent, results_seen, input_stalls);
    $display("Header faults, all chunk stops, wide lengths, restarts and a long output hold");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failing result words", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ccp_pkg.sv
src/ccp_result_fifo.sv
src/chunked_container_parser.sv
verif/tb_top.sv
